@@ rtl/spt_pkg.sv @@
`timescale 1ns / 1ps
package spt_pkg;

  localparam int unsigned MAX_WINDOW = 32;
  localparam int unsigned ADDR_W     = $clog2(MAX_WINDOW);
  localparam int unsigned CNT_W      = ADDR_W + 1;
  localparam int unsigned DIV_STEPS  = 48;
  localparam int unsigned MUL_STEPS  = 32;
  localparam int unsigned IT_W       = 6;

  localparam logic CFG_MODE_LOWS   = 1'b0;
  localparam logic CFG_WINDOW_SIZE = 1'b1;

  typedef struct packed {
    logic [31:0] sample_time;
    logic [31:0] sample_price;
    logic        end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic               pivot_valid;
    logic [31:0]        pivot_time;
    logic [31:0]        pivot_price;
    logic               line_valid;
    logic signed [47:0] line_slope;
    logic signed [63:0] line_intercept;
    logic               end_of_run;
  } out_item_t;

  typedef struct packed {
    logic latch_in;
    logic wr;
    logic rd_head;
    logic latch_head;
    logic eval_upd;
    logic pop;
    logic scan_init;
    logic rd_scan;
    logic scan_step;
    logic line_setup;
    logic div_step;
    logic round;
    logic mul_step;
    logic icpt;
    logic update;
    logic held_clr;
    logic fin_prep;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic count_max;
    logic check_go;
    logic last;
    logic riding;
    logic beyond;
    logic first_more;
    logic scan_more;
    logic scan_fail;
    logic line_ok;
    logic held;
    logic div_last;
    logic mul_last;
  } status_t;

endpackage

@@ rtl/spt_ctrl.sv @@
`timescale 1ns / 1ps
module spt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  spt_pkg::status_t st_i,
  output spt_pkg::cmd_t    cmd_o
);
  import spt_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE      = 17'h00001,
    S_WRITE     = 17'h00002,
    S_CHECK     = 17'h00004,
    S_RD_HEAD   = 17'h00008,
    S_HEAD      = 17'h00010,
    S_EVAL      = 17'h00020,
    S_SCAN_RD   = 17'h00040,
    S_SCAN      = 17'h00080,
    S_PIVOT     = 17'h00100,
    S_SEND_HELD = 17'h00200,
    S_DIV       = 17'h00400,
    S_ROUND     = 17'h00800,
    S_MUL       = 17'h01000,
    S_ICPT      = 17'h02000,
    S_UPDATE    = 17'h04000,
    S_SEND      = 17'h08000,
    S_FIN       = 17'h10000
  } state_e;

  state_e state_q, state_d;
  logic   pre_q, pre_d;
  state_e after_pop;

  assign after_pop   = pre_q ? S_WRITE : S_CHECK;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_SEND) || (state_q == S_SEND_HELD) || (state_q == S_FIN);

  always_comb begin
    state_d = state_q;
    pre_d   = pre_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          pre_d          = st_i.count_max;
          state_d        = st_i.count_max ? S_RD_HEAD : S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.wr = 1'b1;
        pre_d    = 1'b0;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        if (st_i.check_go) begin
          state_d = S_RD_HEAD;
        end else if (st_i.last) begin
          cmd_o.fin_prep = 1'b1;
          state_d        = S_FIN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RD_HEAD: begin
        cmd_o.rd_head = 1'b1;
        state_d       = S_HEAD;
      end
      S_HEAD: begin
        cmd_o.latch_head = 1'b1;
        state_d          = S_EVAL;
      end
      S_EVAL: begin
        if (st_i.riding || st_i.beyond) begin
          cmd_o.eval_upd = 1'b1;
          cmd_o.pop      = 1'b1;
          state_d        = after_pop;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d         = st_i.first_more ? S_SCAN_RD : S_PIVOT;
        end
      end
      S_SCAN_RD: begin
        cmd_o.rd_scan = 1'b1;
        state_d       = S_SCAN;
      end
      S_SCAN: begin
        if (st_i.scan_fail) begin
          cmd_o.pop = 1'b1;
          state_d   = after_pop;
        end else if (st_i.scan_more) begin
          cmd_o.scan_step = 1'b1;
          state_d         = S_SCAN_RD;
        end else begin
          state_d = S_PIVOT;
        end
      end
      S_PIVOT: begin
        if (st_i.held) begin
          state_d = S_SEND_HELD;
        end else begin
          cmd_o.line_setup = 1'b1;
          state_d          = st_i.line_ok ? S_DIV : S_UPDATE;
        end
      end
      S_SEND_HELD: begin
        if (out_ready_i) begin
          cmd_o.held_clr = 1'b1;
          state_d        = S_PIVOT;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (st_i.div_last) state_d = S_ROUND;
      end
      S_ROUND: begin
        cmd_o.round = 1'b1;
        state_d     = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (st_i.mul_last) state_d = S_ICPT;
      end
      S_ICPT: begin
        cmd_o.icpt = 1'b1;
        state_d    = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        cmd_o.pop    = 1'b1;
        state_d      = st_i.last ? after_pop : S_SEND;
      end
      S_SEND: begin
        if (out_ready_i) state_d = after_pop;
      end
      S_FIN: begin
        if (out_ready_i) begin
          cmd_o.clear = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pre_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pre_q   <= pre_d;
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("ready while a result is shown");
  a_pre_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |=> !pre_q)
    else $error("pre flag stuck after write");
  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) && out_ready_i |=> in_ready_o)
    else $error("no return to idle after final result");

endmodule

@@ rtl/spt_datapath.sv @@
`timescale 1ns / 1ps
module spt_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_index_i,
  input  logic [5:0]        cfg_data_i,
  input  spt_pkg::in_item_t in_item_i,
  input  spt_pkg::cmd_t     cmd_i,
  output spt_pkg::status_t  st_o,
  output spt_pkg::out_item_t out_item_o
);
  import spt_pkg::*;

  localparam logic [63:0] IMAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] IMIN = {1'b1, {63{1'b0}}};
  localparam logic [48:0] SMAX = {2'b00, {47{1'b1}}};
  localparam logic [48:0] SNEG = {2'b01, {47{1'b0}}};

  logic             mode_q;
  logic [5:0]       win_q;
  in_item_t         in_q;
  logic [63:0]      mem [MAX_WINDOW];
  logic [63:0]      rd_q;
  logic [ADDR_W-1:0] head_q, k_q, rd_addr, wr_addr;
  logic [CNT_W-1:0] count_q, win_eff, limit;
  logic [31:0]      ext_q, hp_q, ht_q, prev_t_q, prev_p_q;
  logic             riding_q, seen_q, have_prev_q, held_q;
  logic             lv_q, num_neg_q, den_neg_q, sneg_q;
  logic [47:0]      num_q, quo_q;
  logic [31:0]      den_q, rem_q, mplier_q;
  logic [79:0]      mcand_q, acc_q;
  logic [47:0]      slope_q;
  logic [63:0]      icpt_q;
  logic [IT_W-1:0]  it_q;
  out_item_t        res_q;

  logic [32:0]      trial;
  logic             trial_ge;
  logic             rnd;
  logic [48:0]      q_rnd, q_cl;
  logic             s_neg;
  logic [63:0]      big, m_lo, icpt_d;
  logic             ovf;
  logic [31:0]      rd_p;

  always_comb begin
    if (win_q == '0) win_eff = CNT_W'(1);
    else if (win_q > CNT_W'(MAX_WINDOW)) win_eff = CNT_W'(MAX_WINDOW);
    else win_eff = win_q;
  end
  assign limit   = (win_eff < count_q) ? win_eff : count_q;
  assign rd_addr = cmd_i.rd_scan ? head_q + k_q : head_q;
  assign wr_addr = head_q + count_q[ADDR_W-1:0];
  assign rd_p    = rd_q[31:0];

  assign st_o.count_max  = (count_q == CNT_W'(MAX_WINDOW));
  assign st_o.check_go   = in_q.end_of_stream ? (count_q != '0) : (count_q >= win_eff);
  assign st_o.last       = in_q.end_of_stream;
  assign st_o.riding     = riding_q;
  assign st_o.beyond     = mode_q ? (hp_q < ext_q) : (hp_q > ext_q);
  assign st_o.first_more = (limit > CNT_W'(1));
  assign st_o.scan_more  = (({1'b0, k_q} + CNT_W'(1)) < limit);
  assign st_o.scan_fail  = mode_q ? (rd_p <= ext_q) : (rd_p >= ext_q);
  assign st_o.line_ok    = have_prev_q && (ht_q != prev_t_q);
  assign st_o.held       = held_q;
  assign st_o.div_last   = (it_q == IT_W'(DIV_STEPS - 1));
  assign st_o.mul_last   = (it_q == IT_W'(MUL_STEPS - 1));

  assign out_item_o = res_q;

  // restoring divide, one quotient bit per step
  assign trial    = {rem_q, num_q[47]};
  assign trial_ge = trial >= {1'b0, den_q};

  assign rnd   = {rem_q, 1'b0} >= {1'b0, den_q};
  assign q_rnd = {1'b0, quo_q} + 49'(rnd);
  assign s_neg = (num_neg_q != den_neg_q) && (q_rnd != '0);
  always_comb begin
    if (s_neg) q_cl = (q_rnd > SNEG) ? SNEG : q_rnd;
    else       q_cl = (q_rnd > SMAX) ? SMAX : q_rnd;
  end

  assign big  = {16'h0, prev_p_q, 16'h0};
  assign m_lo = acc_q[63:0];
  assign ovf  = |acc_q[79:64];
  always_comb begin
    if (!sneg_q) begin
      if (ovf || (m_lo > big && (m_lo - big) > IMIN)) icpt_d = IMIN;
      else icpt_d = big - m_lo;
    end else begin
      if (ovf || m_lo > (IMAX - big)) icpt_d = IMAX;
      else icpt_d = big + m_lo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) mem[wr_addr] <= {in_q.sample_time, in_q.sample_price};
    if (cmd_i.rd_head || cmd_i.rd_scan) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) in_q <= in_item_i;
    if (cmd_i.latch_head) begin
      hp_q <= rd_q[31:0];
      ht_q <= rd_q[63:32];
    end
    if (cmd_i.line_setup) begin
      num_neg_q <= ext_q < prev_p_q;
      den_neg_q <= ht_q < prev_t_q;
      num_q     <= {(ext_q < prev_p_q) ? prev_p_q - ext_q : ext_q - prev_p_q, 16'h0};
      den_q     <= (ht_q < prev_t_q) ? prev_t_q - ht_q : ht_q - prev_t_q;
      rem_q     <= '0;
      quo_q     <= '0;
      slope_q   <= '0;
      icpt_q    <= '0;
    end
    if (cmd_i.div_step) begin
      num_q <= {num_q[46:0], 1'b0};
      rem_q <= trial_ge ? 32'(trial - {1'b0, den_q}) : trial[31:0];
      quo_q <= {quo_q[46:0], trial_ge};
    end
    if (cmd_i.round) begin
      sneg_q   <= s_neg;
      slope_q  <= s_neg ? 48'(-q_cl) : q_cl[47:0];
      mcand_q  <= {32'h0, q_cl[47:0]};
      mplier_q <= prev_t_q;
      acc_q    <= '0;
    end
    if (cmd_i.mul_step) begin
      if (mplier_q[0]) acc_q <= acc_q + mcand_q;
      mcand_q  <= {mcand_q[78:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[31:1]};
    end
    if (cmd_i.icpt) icpt_q <= icpt_d;
    if (cmd_i.update) begin
      res_q.pivot_valid    <= 1'b1;
      res_q.pivot_time     <= ht_q;
      res_q.pivot_price    <= ext_q;
      res_q.line_valid     <= lv_q;
      res_q.line_slope     <= slope_q;
      res_q.line_intercept <= icpt_q;
      res_q.end_of_run     <= 1'b0;
    end else if (cmd_i.fin_prep) begin
      if (!held_q) res_q <= '{end_of_run: 1'b1, default: '0};
      else res_q.end_of_run <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      win_q       <= 6'd5;
      head_q      <= '0;
      count_q     <= '0;
      k_q         <= '0;
      ext_q       <= '0;
      riding_q    <= 1'b0;
      seen_q      <= 1'b0;
      prev_t_q    <= '0;
      prev_p_q    <= '0;
      have_prev_q <= 1'b0;
      held_q      <= 1'b0;
      lv_q        <= 1'b0;
      it_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_MODE_LOWS:   mode_q <= cfg_data_i[0];
          CFG_WINDOW_SIZE: win_q  <= cfg_data_i;
          default:         win_q  <= win_q;
        endcase
      end
      if (cmd_i.wr) count_q <= count_q + CNT_W'(1);
      if (cmd_i.latch_head && !seen_q) begin
        ext_q  <= rd_q[31:0];
        seen_q <= 1'b1;
      end
      if (cmd_i.eval_upd && st_o.beyond) begin
        ext_q    <= hp_q;
        riding_q <= 1'b0;
      end
      if (cmd_i.scan_init) k_q <= ADDR_W'(1);
      if (cmd_i.scan_step) k_q <= k_q + ADDR_W'(1);
      if (cmd_i.line_setup) begin
        lv_q <= st_o.line_ok;
        it_q <= '0;
      end
      if (cmd_i.div_step || cmd_i.mul_step) it_q <= it_q + IT_W'(1);
      if (cmd_i.round) it_q <= '0;
      if (cmd_i.update) begin
        prev_t_q    <= ht_q;
        prev_p_q    <= ext_q;
        have_prev_q <= 1'b1;
        ext_q       <= hp_q;
        riding_q    <= 1'b1;
        if (in_q.end_of_stream) held_q <= 1'b1;
      end
      if (cmd_i.held_clr) held_q <= 1'b0;
      if (cmd_i.pop) begin
        head_q  <= head_q + ADDR_W'(1);
        count_q <= count_q - CNT_W'(1);
      end
      if (cmd_i.clear) begin
        head_q      <= '0;
        count_q     <= '0;
        ext_q       <= '0;
        riding_q    <= 1'b0;
        seen_q      <= 1'b0;
        prev_t_q    <= '0;
        prev_p_q    <= '0;
        have_prev_q <= 1'b0;
        held_q      <= 1'b0;
      end
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_WINDOW))
    else $error("queue overfilled");
  a_riding_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    riding_q |-> seen_q)
    else $error("riding before first sample");
  a_held_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q |-> in_q.end_of_stream)
    else $error("held result outside final flush");

endmodule

@@ rtl/swing_pivot_trendline.sv @@
`timescale 1ns / 1ps
// Swing high / low pivot detector with trend line to the previous pivot.
// Input channel (in_valid_i / in_ready_o): one price sample per item.
// Output channel (out_valid_o / out_ready_i): pivot results, zero or more
// per input item; an item flagged end_of_stream flushes the queue and always
// ends with a result that has end_of_run set.
// Config channel (cfg_valid_i, always ready): index 0 mode_lows, 1 window_size;
// write only while idle.
// An input item that only enters the queue passes the idle, write and check
// states. Each queued sample that is processed reads, latches and evaluates
// the queue head, plus one memory read and compare per look-ahead sample
// (up to window_size-1, window_size clamped to 1..32); a confirmed pivot with
// a line adds a 48-step divider, rounding, a 32-step shift-add multiplier and
// the intercept step; one without a line skips them; both add the handshake.
// The block is sequential: one item at a time, ready only when idle.
// A stalled receiver holds the block in the result state; nothing is dropped.
// Reset clears stream state, sets mode_lows 0 and window_size 5; the sample
// queue needs no clearing.
module swing_pivot_trendline (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  spt_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output spt_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [5:0]         cfg_data_i
);
  import spt_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg_ready_o = 1'b1;

  spt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  spt_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .st_o       (st),
    .out_item_o (out_item_o)
  );

endmodule

@@ test/swing_pivot_trendline_tb.sv @@
`timescale 1ns / 1ps
module swing_pivot_trendline_tb;
  import spt_pkg::*;

  localparam logic [63:0] SLOPE_MAX = (64'd1 << 47) - 1;
  localparam logic [63:0] ICPT_MAX  = (64'd1 << 63) - 1;
  localparam int unsigned SETTLE    = 600;

  typedef struct {
    bit          cfg;
    bit          cfg_lows;
    logic [5:0]  cfg_win;
    logic [31:0] t;
    logic [31:0] p;
    bit          eos;
    bit          typed;
    bit          pv;
  } row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic      cfg_index_i = CFG_MODE_LOWS;
  logic [5:0] cfg_data_i = '0;

  swing_pivot_trendline i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  bit          mode_lows;
  logic [5:0]  win_size;
  logic [31:0] look_price [MAX_WINDOW];
  logic [31:0] look_time [MAX_WINDOW];
  int unsigned pend;
  logic [31:0] extreme;
  bit          riding;
  bit          seen_first;
  bit          have_prev;
  logic [31:0] prev_t;
  logic [31:0] prev_p;

  out_item_t step_out [$];
  out_item_t pivot_q [$];
  int        mismatches = 0;
  int        out_stall = 0;
  bit        calm = 1'b0;

  function automatic bit fit_line(input logic [31:0] t0, input logic [31:0] p0,
                                  input logic [31:0] t1, input logic [31:0] p1,
                                  output logic [47:0] slope, output logic [63:0] icpt);
    bit nneg, dneg, sneg, ovf;
    logic [31:0] dp, dt;
    logic [63:0] num, den, q, m, big, sv;
    nneg = p1 < p0;
    dneg = t1 < t0;
    dp = nneg ? p0 - p1 : p1 - p0;
    dt = dneg ? t0 - t1 : t1 - t0;
    num = {16'b0, dp, 16'b0};
    den = {32'b0, dt};
    slope = '0;
    icpt = '0;
    if (den == 0) return 1'b0;
    q = (num * 2 + den) / (den * 2);
    sneg = (nneg != dneg) && q != 0;
    if (sneg) begin
      if (q > SLOPE_MAX + 1) q = SLOPE_MAX + 1;
    end else if (q > SLOPE_MAX) begin
      q = SLOPE_MAX;
    end
    sv = sneg ? 64'd0 - q : q;
    slope = sv[47:0];
    ovf = (t0 != 0) && (q > (64'hFFFF_FFFF_FFFF_FFFF / {32'b0, t0}));
    m = ovf ? 64'd0 : q * {32'b0, t0};
    big = {16'b0, p0, 16'b0};
    if (!sneg) begin
      if (ovf || (m > big && m - big > ICPT_MAX + 1)) icpt = ICPT_MAX + 1;
      else if (m <= big) icpt = big - m;
      else icpt = 64'd0 - (m - big);
    end else begin
      if (ovf || m > ICPT_MAX - big) icpt = ICPT_MAX;
      else icpt = big + m;
    end
    return 1'b1;
  endfunction

  function automatic void add_pivot(input logic [31:0] t, input logic [31:0] p);
    out_item_t r;
    logic [47:0] s;
    logic [63:0] ic;
    bit lv;
    lv = 1'b0;
    s = '0;
    ic = '0;
    if (have_prev) lv = fit_line(prev_t, prev_p, t, p, s, ic);
    if (!lv) begin
      s = '0;
      ic = '0;
    end
    prev_t = t;
    prev_p = p;
    have_prev = 1'b1;
    r = '0;
    r.pivot_valid = 1'b1;
    r.pivot_time = t;
    r.pivot_price = p;
    r.line_valid = lv;
    r.line_slope = s;
    r.line_intercept = ic;
    if (step_out.size() < 32) step_out.insert(step_out.size(), r);
  endfunction

  function automatic void scan_head(input int unsigned w);
    logic [31:0] p, t;
    bit beyond, ok;
    p = look_price[0];
    t = look_time[0];
    if (!seen_first) begin
      extreme = p;
      seen_first = 1'b1;
    end
    beyond = mode_lows ? (p < extreme) : (p > extreme);
    if (!riding) begin
      if (beyond) begin
        extreme = p;
      end else begin
        ok = 1'b1;
        for (int k = 1; k < w && k < pend; k++) begin
          if (mode_lows ? (look_price[k] <= extreme) : (look_price[k] >= extreme)) ok = 1'b0;
        end
        if (ok) begin
          add_pivot(t, extreme);
          extreme = p;
          riding = 1'b1;
        end
      end
    end else if (beyond) begin
      riding = 1'b0;
      extreme = p;
    end
    for (int k = 1; k < pend; k++) begin
      look_price[k-1] = look_price[k];
      look_time[k-1] = look_time[k];
    end
    if (pend > 0) pend--;
  endfunction

  function automatic void clear_stream();
    pend = 0;
    extreme = '0;
    riding = 1'b0;
    seen_first = 1'b0;
    have_prev = 1'b0;
    prev_t = '0;
    prev_p = '0;
  endfunction

  function automatic void trend_step(input logic [31:0] t, input logic [31:0] p, input bit eos);
    out_item_t r;
    int unsigned w;
    step_out.delete();
    w = (win_size == 0) ? 1 : ((win_size > MAX_WINDOW) ? MAX_WINDOW : win_size);
    if (pend >= MAX_WINDOW) scan_head(w);
    look_time[pend] = t;
    look_price[pend] = p;
    pend++;
    if (!eos) begin
      while (pend >= w) scan_head(w);
    end else begin
      while (pend > 0) scan_head(w);
      if (step_out.size() > 0) begin
        r = step_out[$];
        r.end_of_run = 1'b1;
        step_out[step_out.size()-1] = r;
      end else begin
        r = '0;
        r.end_of_run = 1'b1;
        step_out.insert(step_out.size(), r);
      end
      clear_stream();
    end
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_sample(input logic [31:0] t, input logic [31:0] p, input bit eos,
                             input bit typed, input bit pv);
    int g;
    out_item_t r;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= '{sample_time: t, sample_price: p, end_of_stream: eos};
    do @(posedge clk_i); while (!in_ready_o);
    trend_step(t, p, eos);
    if (typed) begin
      r = '0;
      r.pivot_valid = pv;
      r.pivot_time = pv ? t : 32'd0;
      r.pivot_price = pv ? p : 32'd0;
      r.end_of_run = 1'b1;
      pivot_q.insert(pivot_q.size(), r);
    end else begin
      foreach (step_out[i]) pivot_q.insert(pivot_q.size(), step_out[i]);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pivot_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_cfg(input bit lows, input logic [5:0] win);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_MODE_LOWS;
    cfg_data_i <= {5'b0, lows};
    do @(posedge clk_i); while (!cfg_ready_o);
    mode_lows = lows;
    cfg_index_i <= CFG_WINDOW_SIZE;
    cfg_data_i <= win;
    do @(posedge clk_i); while (!cfg_ready_o);
    win_size = win;
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pivot_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %p", out_item_o);
      end else if (pivot_q[0].pivot_valid !== out_item_o.pivot_valid ||
                   pivot_q[0].pivot_time !== out_item_o.pivot_time ||
                   pivot_q[0].pivot_price !== out_item_o.pivot_price ||
                   pivot_q[0].line_valid !== out_item_o.line_valid ||
                   pivot_q[0].line_slope !== out_item_o.line_slope ||
                   pivot_q[0].line_intercept !== out_item_o.line_intercept ||
                   pivot_q[0].end_of_run !== out_item_o.end_of_run) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: exp %p got %p", pivot_q[0], out_item_o);
        void'(pivot_q.pop_front());
      end else begin
        void'(pivot_q.pop_front());
      end
    end
    if (out_stall > 0) begin
      out_stall--;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    #100ms;
    $display("end of test: mismatches");
    $finish;
  end

  row_t rows [] = '{
    '{0, 0, 5, 100, 500, 1, 1, 1},
    '{0, 0, 5, 0, 32'hFFFF_FFFF, 1, 1, 1},
    '{0, 0, 5, 32'hFFFF_FFFF, 0, 1, 1, 1},
    '{0, 0, 5, 0, 0, 0, 0, 0},
    '{0, 0, 5, 1, 32'hFFFF_FFFF, 0, 0, 0},
    '{0, 0, 5, 2, 5, 0, 0, 0},
    '{0, 0, 5, 3, 4, 0, 0, 0},
    '{0, 0, 5, 4, 3, 0, 0, 0},
    '{0, 0, 5, 5, 2, 0, 0, 0},
    '{0, 0, 5, 6, 100, 0, 0, 0},
    '{0, 0, 5, 7, 50, 0, 0, 0},
    '{0, 0, 5, 8, 40, 0, 0, 0},
    '{0, 0, 5, 10, 20, 1, 0, 0},
    '{1, 0, 1, 100, 0, 0, 0, 0},
    '{0, 0, 1, 100, 32'hFFFF_FFFF, 0, 0, 0},
    '{0, 0, 1, 100, 0, 0, 0, 0},
    '{0, 0, 1, 101, 1, 0, 0, 0},
    '{0, 0, 1, 101, 0, 0, 0, 0},
    '{0, 0, 1, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 0},
    '{0, 0, 1, 32'hFFFF_FFFF, 0, 0, 0, 0},
    '{0, 0, 1, 32'hFFFF_FFFF, 5, 0, 0, 0},
    '{0, 0, 1, 32'hFFFF_FFFF, 0, 0, 0, 0},
    '{0, 0, 1, 0, 7, 0, 0, 0},
    '{0, 0, 1, 0, 7, 0, 0, 0},
    '{0, 0, 1, 1, 0, 1, 0, 0},
    '{1, 1, 0, 0, 10, 0, 0, 0},
    '{0, 1, 0, 1, 5, 0, 0, 0},
    '{0, 1, 0, 2, 7, 0, 0, 0},
    '{0, 1, 0, 3, 9, 1, 1, 0}
  };

  bit          phase_lows [8] = '{0, 1, 0, 1, 0, 1, 0, 1};
  logic [5:0]  phase_win [8] = '{5, 3, 32, 63, 0, 1, 2, 8};

  initial begin
    logic [31:0] t, p;
    bit eos;
    mode_lows = 1'b0;
    win_size = 6'd5;
    clear_stream();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].cfg) begin
        drain();
        write_cfg(rows[i].cfg_lows, rows[i].cfg_win);
      end
      send_sample(rows[i].t, rows[i].p, rows[i].eos, rows[i].typed, rows[i].pv);
    end

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      write_cfg(phase_lows[ph], phase_win[ph]);
      calm = (ph == 2);
      t = $urandom;
      p = $urandom_range(1000, 100000);
      for (int n = 0; n < 38; n++) begin
        if ($urandom_range(0, 7) == 0) begin
          t = $urandom;
          p = $urandom;
        end else begin
          t = ($urandom_range(0, 15) == 0) ? t - $urandom_range(0, 3) : t + $urandom_range(0, 4);
          p = p + $urandom_range(0, 40) - 20;
        end
        eos = ($urandom_range(0, 14) == 0);
        if (n == 37 && (ph % 2 == 0 || ph == 7)) eos = 1'b1;
        send_sample(t, p, eos, 1'b0, 1'b0);
      end
    end
    calm = 1'b0;
    drain();

    if (mismatches == 0 && pivot_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ swing_pivot_trendline.f @@
rtl/spt_pkg.sv
rtl/spt_ctrl.sv
rtl/spt_datapath.sv
rtl/swing_pivot_trendline.sv
test/swing_pivot_trendline_tb.sv
